/* design/trapezoid_rule_integrator_macros.svh */
// assertion macros shared by the integrator modules
`ifndef TRAPEZOID_RULE_INTEGRATOR_MACROS_SVH
`define TRAPEZOID_RULE_INTEGRATOR_MACROS_SVH
`ifndef SYNTHESIS
`define TRAPZ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TRAPZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TRAPZ_ASSERT_NOW(label, clk, rst, ante, cons)
`define TRAPZ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/trapz_pkg.sv */
package trapz_pkg;

   localparam int X_W      = 32;
   localparam int CNT_W    = 13;
   localparam int STEP_W   = 31;
   localparam int FRAC_W   = 28;
   localparam int F_W      = FRAC_W + 1;
   localparam int DEN_W    = 36;

   localparam int MAX_POINTS_DEFAULT = 4096;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2684);
   localparam logic [DEN_W-1:0]  FIVE_Q28   = DEN_W'(64'd5 << FRAC_W);

   typedef struct packed {
      logic                  start;
      logic signed [X_W-1:0] x;
   } eval_req_type;

   typedef struct packed {
      logic                  done;
      logic signed [F_W-1:0] f;
   } eval_rsp_type;

endpackage

/* design/trapezoid_rule_integrator.sv */
// the point count is clamped to MAX_POINTS, and a count of 0 is handled like a count of 1
// every sample runs through a bit-serial square and a restoring divide,
//   the final scale by the step is a bit-serial multiply
// one request at a time: req_stall is high until the block is back in idle; the next is taken while a result waits
// synchronous active-high reset clears control state and loads step_size with 2684
`include "trapezoid_rule_integrator_macros.svh"

module trapezoid_rule_integrator #(
   parameter int MAX_POINTS = trapz_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [trapz_pkg::X_W-1:0] req_start_point,
   input  logic signed [trapz_pkg::X_W-1:0] req_end_point,
   input  logic [trapz_pkg::CNT_W-1:0]      req_point_count,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [trapz_pkg::X_W-1:0] rsp_integral,
   output logic                             rsp_saturated,
   input  logic                             csr_wr_en,
   input  logic [trapz_pkg::STEP_W-1:0]     csr_wr_data
);

   localparam int X_W    = trapz_pkg::X_W;
   localparam int CNT_W  = trapz_pkg::CNT_W;
   localparam int STEP_W = trapz_pkg::STEP_W;
   localparam int RC_W   = $clog2(MAX_POINTS);
   localparam int PC_W   = (CNT_W > $clog2(MAX_POINTS + 1)) ? CNT_W : $clog2(MAX_POINTS + 1);
   localparam int XR_W   = X_W + RC_W + 1;
   localparam int ACC_W  = RC_W + 31;
   localparam int PR_W   = ACC_W + 2;
   localparam int CW     = $clog2(STEP_W);
   localparam logic [CW-1:0]  SC_LAST = CW'(STEP_W - 1);
   localparam logic [X_W-1:0] Q_MAX   = {1'b0, {(X_W-1){1'b1}}};
   localparam logic [X_W-1:0] Q_MIN   = {1'b1, {(X_W-1){1'b0}}};

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EVAL   = 5'b00010,
      ST_MAGN   = 5'b00100,
      ST_SCALE  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      PT_A     = 3'b001,
      PT_B     = 3'b010,
      PT_INNER = 3'b100
   } point_type;

   state_type               state_ff, state_in;
   point_type               sel_ff, sel_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic signed [X_W-1:0]   b_ff, b_in;
   logic signed [XR_W-1:0]  x_run_ff, x_run_in;
   logic [RC_W-1:0]         rem_cnt_ff, rem_cnt_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    neg_ff, neg_in;
   logic [ACC_W-1:0]        mag_ff, mag_in;
   logic [STEP_W-1:0]       hs_ff, hs_in;
   logic [ACC_W-1:0]        p_ff, p_in;
   logic [STEP_W-1:0]       lo_ff, lo_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [X_W-1:0]   rsp_integral_ff, rsp_integral_in;
   logic                    rsp_saturated_ff, rsp_saturated_in;

   trapz_pkg::eval_req_type eval_req;
   trapz_pkg::eval_rsp_type eval_rsp;

   logic [PC_W-1:0]         n_ext, n_cl;
   logic [RC_W-1:0]         inner_cnt;
   logic                    x_in_range;
   logic [X_W-1:0]          x_clamp;
   logic signed [ACC_W-1:0] f_ext;
   logic [ACC_W:0]          sc_sum;
   logic [PR_W-1:0]         prod;
   logic                    hi_nz, sat;
   logic                    out_free;

   trapz_integrand u_integrand (
      .clock    (clock),
      .reset    (reset),
      .eval_req (eval_req),
      .eval_rsp (eval_rsp)
   );

   assign n_ext     = PC_W'(req_point_count);
   assign n_cl      = (n_ext > PC_W'(MAX_POINTS)) ? PC_W'(MAX_POINTS) : n_ext;
   assign inner_cnt = (n_cl == '0) ? '0 : RC_W'(n_cl - PC_W'(1));

   // running abscissa is exact, clamp only on the way into the integrand
   assign x_in_range = (&x_run_ff[XR_W-1:X_W-1]) || !(|x_run_ff[XR_W-1:X_W-1]);
   assign x_clamp    = x_in_range ? x_run_ff[X_W-1:0] : (x_run_ff[XR_W-1] ? Q_MIN : Q_MAX);

   assign f_ext  = ACC_W'(eval_rsp.f);
   assign sc_sum = {1'b0, p_ff} + (hs_ff[0] ? {1'b0, mag_ff} : '0);
   // product >> 29: keep the top two bits that shifted out of p
   assign prod   = {p_ff, lo_ff[STEP_W-1:STEP_W-2]};
   assign hi_nz  = |prod[PR_W-1:X_W];
   assign sat    = neg_ff ? (hi_nz || (prod[X_W-1] && (|prod[X_W-2:0])))
                          : (hi_nz || prod[X_W-1]);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      sel_in           = sel_ff;
      step_in          = step_ff;
      b_in             = b_ff;
      x_run_in         = x_run_ff;
      rem_cnt_in       = rem_cnt_ff;
      acc_in           = acc_ff;
      neg_in           = neg_ff;
      mag_in           = mag_ff;
      hs_in            = hs_ff;
      p_in             = p_ff;
      lo_in            = lo_ff;
      cnt_in           = cnt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_integral_in  = rsp_integral_ff;
      rsp_saturated_in = rsp_saturated_ff;
      eval_req.start   = 1'b0;
      eval_req.x       = req_start_point;

      if (csr_wr_en) begin
         step_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               b_in           = req_end_point;
               x_run_in       = XR_W'(req_start_point) + XR_W'(signed'({1'b0, step_ff}));
               rem_cnt_in     = inner_cnt;
               acc_in         = '0;
               sel_in         = PT_A;
               eval_req.start = 1'b1;
               eval_req.x     = req_start_point;
               state_in       = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_rsp.done) begin
               acc_in = acc_ff + ((sel_ff == PT_INNER) ? (f_ext <<< 1) : f_ext);
               case (sel_ff)
                  PT_A: begin
                     sel_in         = PT_B;
                     eval_req.start = 1'b1;
                     eval_req.x     = b_ff;
                  end
                  PT_B, PT_INNER: begin
                     if (rem_cnt_ff != '0) begin
                        sel_in         = PT_INNER;
                        eval_req.start = 1'b1;
                        eval_req.x     = x_clamp;
                        x_run_in       = x_run_ff + XR_W'(signed'({1'b0, step_ff}));
                        rem_cnt_in     = rem_cnt_ff - 1'b1;
                     end else begin
                        state_in = ST_MAGN;
                     end
                  end
                  default: begin
                     state_in = ST_MAGN;
                  end
               endcase
            end
         end
         ST_MAGN: begin
            neg_in   = acc_ff[ACC_W-1];
            mag_in   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
            hs_in    = step_ff;
            p_in     = '0;
            cnt_in   = '0;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            p_in   = sc_sum[ACC_W:1];
            lo_in  = {sc_sum[0], lo_ff[STEP_W-1:1]};
            hs_in  = hs_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SC_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_saturated_in = sat;
               if (sat) begin
                  rsp_integral_in = neg_ff ? Q_MIN : Q_MAX;
               end else begin
                  rsp_integral_in = neg_ff ? -prod[X_W-1:0] : prod[X_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= PT_A;
         step_ff      <= trapz_pkg::STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b_ff             <= b_in;
      x_run_ff         <= x_run_in;
      rem_cnt_ff       <= rem_cnt_in;
      acc_ff           <= acc_in;
      neg_ff           <= neg_in;
      mag_ff           <= mag_in;
      hs_ff            <= hs_in;
      p_ff             <= p_in;
      lo_ff            <= lo_in;
      cnt_ff           <= cnt_in;
      rsp_integral_ff  <= rsp_integral_in;
      rsp_saturated_ff <= rsp_saturated_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_integral  = rsp_integral_ff;
   assign rsp_saturated = rsp_saturated_ff;

   `TRAPZ_ASSERT_NEXT(a_transfer_starts_eval, clock, reset, req_valid && !req_stall, state_ff == ST_EVAL)
   `TRAPZ_ASSERT_NOW(a_done_only_in_eval, clock, reset, eval_rsp.done, state_ff == ST_EVAL)
   `TRAPZ_ASSERT_NOW(a_sat_is_clamped, clock, reset, rsp_valid_ff && rsp_saturated_ff, rsp_integral_ff == Q_MAX || rsp_integral_ff == Q_MIN)
   `TRAPZ_ASSERT_NEXT(a_finish_loads_rsp, clock, reset, state_ff == ST_FINISH && out_free, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

/* design/trapz_integrand.sv */
`include "trapezoid_rule_integrator_macros.svh"

module trapz_integrand (
   input  logic                    clock,
   input  logic                    reset,
   input  trapz_pkg::eval_req_type eval_req,
   output trapz_pkg::eval_rsp_type eval_rsp
);

   localparam int X_W    = trapz_pkg::X_W;
   localparam int FRAC_W = trapz_pkg::FRAC_W;
   localparam int F_W    = trapz_pkg::F_W;
   localparam int DEN_W  = trapz_pkg::DEN_W;
   localparam int CW     = $clog2(X_W);
   localparam logic [CW-1:0] SQ_LAST  = CW'(X_W - 1);
   localparam logic [CW-1:0] DIV_LAST = CW'(FRAC_W - 1);

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_SQUARE = 5'b00010,
      PH_DENOM  = 5'b00100,
      PH_DIVIDE = 5'b01000,
      PH_FINISH = 5'b10000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [X_W-1:0]        m_ff, m_in;
   logic [X_W-1:0]        mult_ff, mult_in;
   logic [X_W-1:0]        p_ff, p_in;
   logic [X_W-1:0]        lo_ff, lo_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [FRAC_W-1:0]     quo_ff, quo_in;
   logic                  done_ff, done_in;
   logic signed [F_W-1:0] f_ff, f_in;

   logic [X_W:0]          sq_sum;
   logic [DEN_W-1:0]      rem_shift;
   logic [DEN_W:0]        diff;
   logic [X_W-1:0]        x_mag;

   assign x_mag     = eval_req.x[X_W-1] ? X_W'(-eval_req.x) : X_W'(eval_req.x);
   // one multiplier bit per cycle, low product bits shift out into lo
   assign sq_sum    = {1'b0, p_ff} + (mult_ff[0] ? {1'b0, m_ff} : '0);
   assign rem_shift = {rem_ff[DEN_W-2:0], 1'b0};
   assign diff      = {1'b0, rem_shift} - {1'b0, den_ff};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      m_in     = m_ff;
      mult_in  = mult_ff;
      p_in     = p_ff;
      lo_in    = lo_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      done_in  = 1'b0;
      f_in     = f_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (eval_req.start) begin
               neg_in   = eval_req.x[X_W-1];
               m_in     = x_mag;
               mult_in  = x_mag;
               p_in     = '0;
               cnt_in   = '0;
               phase_in = PH_SQUARE;
            end
         end
         PH_SQUARE: begin
            p_in    = sq_sum[X_W:1];
            lo_in   = {sq_sum[0], lo_ff[X_W-1:1]};
            mult_in = mult_ff >> 1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == SQ_LAST) begin
               phase_in = PH_DENOM;
            end
         end
         PH_DENOM: begin
            den_in   = DEN_W'({p_ff, lo_ff[X_W-1:FRAC_W]}) + trapz_pkg::FIVE_Q28;
            // numerator is m << 28 and m < den, so quotient fits FRAC_W bits
            rem_in   = DEN_W'(m_ff);
            cnt_in   = '0;
            phase_in = PH_DIVIDE;
         end
         PH_DIVIDE: begin
            if (!diff[DEN_W]) begin
               rem_in = diff[DEN_W-1:0];
               quo_in = {quo_ff[FRAC_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[FRAC_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               phase_in = PH_FINISH;
            end
         end
         PH_FINISH: begin
            done_in  = 1'b1;
            f_in     = neg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      m_ff    <= m_in;
      mult_ff <= mult_in;
      p_ff    <= p_in;
      lo_ff   <= lo_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      f_ff    <= f_in;
   end

   assign eval_rsp.done = done_ff;
   assign eval_rsp.f    = f_ff;

   `TRAPZ_ASSERT_NOW(a_start_when_idle, clock, reset, eval_req.start, phase_ff == PH_IDLE)
   `TRAPZ_ASSERT_NOW(a_rem_below_den, clock, reset, phase_ff == PH_DIVIDE, rem_ff < den_ff)
   `TRAPZ_ASSERT_NOW(a_den_floor, clock, reset, phase_ff == PH_DIVIDE, den_ff >= trapz_pkg::FIVE_Q28)

endmodule

/* dv/tb.sv */
localparam longint unsigned DEN_OFFSET = 64'd5 << trapz_pkg::FRAC_W;
localparam longint X_CEIL = 64'sd2147483647;
localparam longint X_FLOOR = -64'sd2147483648;
localparam logic signed [trapz_pkg::X_W-1:0] SAT_HIGH = 32'sh7FFF_FFFF;
localparam logic signed [trapz_pkg::X_W-1:0] SAT_LOW = 32'sh8000_0000;

typedef struct packed {
   logic signed [trapz_pkg::X_W-1:0] integral;
   logic                             saturated;
} integral_result_type;

class integral_scoreboard;
   logic [trapz_pkg::STEP_W-1:0] step;
   integral_result_type          awaited[$];
   int                           errors;

   function new();
      step = trapz_pkg::STEP_RESET;
      errors = 0;
   endfunction

   function int pending();
      return awaited.size();
   endfunction

   // x / (x*x + 5), rounded toward zero
   function longint sample_value(longint x);
      longint unsigned mag;
      longint unsigned den;
      longint unsigned quo;
      mag = (x < 0) ? longint'(-x) : longint'(x);
      den = ((mag * mag) >> trapz_pkg::FRAC_W) + DEN_OFFSET;
      quo = (mag << trapz_pkg::FRAC_W) / den;
      return (x < 0) ? -longint'(quo) : longint'(quo);
   endfunction

   function void note_request(logic signed [trapz_pkg::X_W-1:0] start_x,
                              logic signed [trapz_pkg::X_W-1:0] end_x,
                              logic [trapz_pkg::CNT_W-1:0] count);
      longint              acc;
      longint              x;
      longint              h;
      longint unsigned     mag;
      longint unsigned     prod;
      longint unsigned     neg_prod;
      int                  n;
      int                  k;
      integral_result_type r;
      h = longint'(step);
      n = int'(count);
      if (n > trapz_pkg::MAX_POINTS_DEFAULT) n = trapz_pkg::MAX_POINTS_DEFAULT;
      acc = sample_value(longint'(start_x)) + sample_value(longint'(end_x));
      for (k = 1; k < n; k++) begin
         x = longint'(start_x) + longint'(k) * h;
         if (x > X_CEIL) x = X_CEIL;
         else if (x < X_FLOOR) x = X_FLOOR;
         acc += 2 * sample_value(x);
      end
      mag = (acc < 0) ? longint'(-acc) : longint'(acc);
      // sum * h / 2^29 split into high and low words
      prod = (((mag >> 32) * longint'(step)) << 3)
           + (((mag & 64'hFFFF_FFFF) * longint'(step)) >> 29);
      r.saturated = 1'b0;
      if (acc >= 0) begin
         if (prod > 64'd2147483647) begin
            r.integral = SAT_HIGH;
            r.saturated = 1'b1;
         end else begin
            r.integral = prod[31:0];
         end
      end else begin
         if (prod > 64'd2147483648) begin
            r.integral = SAT_LOW;
            r.saturated = 1'b1;
         end else begin
            neg_prod = -prod;
            r.integral = neg_prod[31:0];
         end
      end
      awaited.push_back(r);
   endfunction

   task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
   endtask

   task check_result(logic signed [trapz_pkg::X_W-1:0] integral, logic saturated);
      integral_result_type want;
      if (awaited.size() == 0) begin
         report($sformatf("integral %0d arrived with nothing awaited", integral));
      end else begin
         want = awaited.pop_front();
         if (integral !== want.integral)
            report($sformatf("integral %0d, predicted %0d", integral, want.integral));
         if (saturated !== want.saturated)
            report($sformatf("saturated %b, predicted %b", saturated, want.saturated));
      end
   endtask

   task flush_leftovers();
      integral_result_type want;
      while (awaited.size() != 0) begin
         want = awaited.pop_front();
         report($sformatf("integral %0d never arrived", want.integral));
      end
   endtask
endclass

module tb;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int SETTLE_CYCLES = 200;
   localparam logic signed [31:0] X_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] X_MIN = 32'sh8000_0000;
   localparam logic [30:0] STEP_MAX = 31'h7FFF_FFFF;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic signed [trapz_pkg::X_W-1:0] req_start_point;
   logic signed [trapz_pkg::X_W-1:0] req_end_point;
   logic [trapz_pkg::CNT_W-1:0]      req_point_count;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic signed [trapz_pkg::X_W-1:0] rsp_integral;
   logic                             rsp_saturated;
   logic                             csr_wr_en;
   logic [trapz_pkg::STEP_W-1:0]     csr_wr_data;

   integral_scoreboard sb;
   bit                 idle_on;
   bit                 stall_on;
   int                 cycle_count;

   trapezoid_rule_integrator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_point(req_start_point),
      .req_end_point(req_end_point),
      .req_point_count(req_point_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_integral(rsp_integral),
      .rsp_saturated(rsp_saturated),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** trapezoid_rule_integrator: FAILED **");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_integral, rsp_saturated);
   end

   // returns right after the transfer edge; valid stays up for a following request
   task automatic send_request(logic signed [31:0] start_x, logic signed [31:0] end_x,
                               logic [12:0] count);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_start_point <= start_x;
      req_end_point <= end_x;
      req_point_count <= count;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(start_x, end_x, count);
   endtask

   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // called at a falling edge with the block idle
   task automatic write_step(logic [30:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.step = value;
   endtask

   task automatic random_phase(int items);
      logic signed [31:0] start_x;
      logic signed [31:0] end_x;
      logic [12:0]        count;
      int                 i;
      for (i = 0; i < items; i++) begin
         start_x = $urandom;
         end_x = $urandom;
         // push some starts near the edges of the range
         if ($urandom_range(0, 4) == 0)
            start_x[31:24] = ($urandom_range(0, 1) != 0) ? 8'h7F : 8'h80;
         if ($urandom_range(0, 9) < 7) count = 13'($urandom_range(0, 24));
         else count = 13'($urandom_range(25, 200));
         send_request(start_x, end_x, count);
      end
   endtask

   initial begin
      int p;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_start_point = '0;
      req_end_point = '0;
      req_point_count = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      idle_on = 1'b1;
      stall_on = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // step left at its reset value
      send_request(32'sh0000_0000, 32'sh0000_0000, 13'd0);
      send_request(X_MAX, X_MIN, 13'd1);
      send_request(X_MIN, X_MAX, 13'd2);
      send_request(32'sh1000_0000, 32'sh2000_0000, 13'd5);
      send_request(32'shF000_0000, 32'shD000_0000, 13'd3);
      // count above the maximum, interior points run past the top of the range
      send_request(X_MAX, X_MIN, 13'h1FFF);
      send_request(X_MIN, 32'sh0000_0000, 13'd4096);
      drain_requests();

      write_step(STEP_MAX);
      send_request(32'sh1000_0000, 32'sh7000_0000, 13'd100);
      send_request(X_MIN, X_MAX, 13'd3);
      send_request(32'sh0000_0000, X_MIN, 13'd2);
      send_request(X_MAX, 32'sh0000_0000, 13'd0);
      send_request(32'shE000_0000, 32'sh0000_0001, 13'd50);
      drain_requests();

      write_step(31'd0);
      send_request(32'sh1234_5678, 32'shE000_0000, 13'd20);
      send_request(X_MIN, X_MIN, 13'd1);
      drain_requests();

      write_step(31'h0400_0000);
      send_request(X_MIN, X_MAX, 13'd64);
      send_request(32'shE000_0000, 32'sh2000_0000, 13'd17);
      drain_requests();

      for (p = 0; p < 5; p++) begin
         idle_on = (p < 4) && (p != 1);
         stall_on = (p < 4) && (p != 2);
         case ($urandom_range(0, 2))
            0: write_step(31'($urandom));
            1: write_step(31'($urandom_range(1, 32'h0400_0000)));
            default: write_step(31'($urandom_range(32'h0400_0000, 32'h7FFF_FFFF)));
         endcase
         random_phase(20);
         drain_requests();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      sb.flush_leftovers();
      if (sb.errors == 0)
         $display("** trapezoid_rule_integrator: PASSED **");
      else
         $display("** trapezoid_rule_integrator: FAILED **");
      $finish;
   end
endmodule
